// File: src/mbaa_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and the multiply-accumulate command type of the escape-time evaluator.
package mbaa_pkg;

   // Iteration limit and pixel coordinate width
   localparam int MaxIter  = 512;
   localparam int DimBits  = 12;

   // Fixed-point format and datapath widths
   localparam int FracBits = 52;
   localparam int RegW     = 64;
   localparam int MulW     = 32;
   localparam int AccW     = 128;

   // Count, sum and result widths
   localparam int CountW   = $clog2(MaxIter + 1);
   localparam int SumW     = CountW + 2;
   localparam int OutW     = 10;

   // Register index width of the control port
   localparam int CsrIdxW  = 3;

   // Register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_CENTER_X     = 3'd0,
      CSR_CENTER_Y     = 3'd1,
      CSR_STEP_SIZE    = 3'd2,
      CSR_IMAGE_WIDTH  = 3'd3,
      CSR_IMAGE_HEIGHT = 3'd4
   } csr_index_type;

   // Left shift applied to a partial product before it is accumulated
   typedef enum logic [1:0] {
      SH_0  = 2'd0,
      SH_32 = 2'd1,
      SH_33 = 2'd2,
      SH_64 = 2'd3
   } mac_shift_type;

   // Accumulator that a partial product lands in
   typedef enum logic [1:0] {
      ACC_A = 2'd0,
      ACC_B = 2'd1,
      ACC_P = 2'd2
   } acc_sel_type;

   // One command to the shared multiply-accumulate unit
   typedef struct packed {
      logic          valid;
      logic          clear;
      acc_sel_type   dest;
      mac_shift_type shift;
      logic [MulW-1:0] opa;
      logic [MulW-1:0] opb;
   } mac_op_type;

endpackage

// File: src/mbaa_mac.sv
`timescale 1ns / 1ps
// Shared 32x32 multiplier with three 128-bit shift-and-add accumulators.
module mbaa_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  mbaa_pkg::mac_op_type          op,
   output logic [mbaa_pkg::AccW-1:0]     acc_a,
   output logic [mbaa_pkg::AccW-1:0]     acc_b,
   output logic [mbaa_pkg::AccW-1:0]     acc_p
);

   logic [2*mbaa_pkg::MulW-1:0] prod_ff;
   logic [2*mbaa_pkg::MulW-1:0] prod_in;
   logic                        tag_valid_ff;
   logic                        tag_clear_ff;
   mbaa_pkg::acc_sel_type       tag_dest_ff;
   mbaa_pkg::mac_shift_type     tag_shift_ff;

   logic [mbaa_pkg::AccW-1:0]   acc_a_ff;
   logic [mbaa_pkg::AccW-1:0]   acc_b_ff;
   logic [mbaa_pkg::AccW-1:0]   acc_p_ff;
   logic [mbaa_pkg::AccW-1:0]   addend;
   logic [mbaa_pkg::AccW-1:0]   base;
   logic [mbaa_pkg::AccW-1:0]   acc_sum;

   // Multiply stage: register the product before it is added
   assign prod_in = op.opa * op.opb;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_valid_ff <= 1'b0;
      end else begin
         tag_valid_ff <= op.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (op.valid) begin
         prod_ff      <= prod_in;
         tag_clear_ff <= op.clear;
         tag_dest_ff  <= op.dest;
         tag_shift_ff <= op.shift;
      end
   end

   // Align the product to its weight
   always_comb begin
      unique case (tag_shift_ff)
         mbaa_pkg::SH_0:  addend = {64'b0, prod_ff};
         mbaa_pkg::SH_32: addend = {32'b0, prod_ff, 32'b0};
         mbaa_pkg::SH_33: addend = {31'b0, prod_ff, 33'b0};
         mbaa_pkg::SH_64: addend = {prod_ff, 64'b0};
         default:         addend = '0;
      endcase
   end

   // Pick the running sum, or zero when the command starts a fresh sum
   always_comb begin
      unique case (tag_dest_ff)
         mbaa_pkg::ACC_A: base = acc_a_ff;
         mbaa_pkg::ACC_B: base = acc_b_ff;
         mbaa_pkg::ACC_P: base = acc_p_ff;
         default:         base = '0;
      endcase
      if (tag_clear_ff) begin
         base = '0;
      end
      acc_sum = base + addend;
   end

   // Accumulate stage
   always_ff @(posedge clock) begin
      if (tag_valid_ff) begin
         unique case (tag_dest_ff)
            mbaa_pkg::ACC_A: acc_a_ff <= acc_sum;
            mbaa_pkg::ACC_B: acc_b_ff <= acc_sum;
            mbaa_pkg::ACC_P: acc_p_ff <= acc_sum;
            default: ;
         endcase
      end
   end

   assign acc_a = acc_a_ff;
   assign acc_b = acc_b_ff;
   assign acc_p = acc_p_ff;

endmodule

// File: src/mandelbrot_escape_time_aa4_top.sv
`timescale 1ns / 1ps
// Top level of the four-sample anti-aliased escape-time evaluator.
//
// Pulse start with a pixel while busy is low; busy rises in the next cycle and stays
// high until the result is out. The result appears on rsp_iteration_count for exactly
// one cycle with rsp_valid high and cannot be held off. All products go through one
// 32x32 multiplier. A pixel first maps its four sample points and then, per sample,
// iterates z until an iteration escapes at its check or 512 iterations are done, and
// then registers the mean of the four counts for the strobe. Write the control
// registers only while busy is low.
module mandelbrot_escape_time_aa4_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [mbaa_pkg::DimBits-1:0]     req_pixel_x,
   input  logic [mbaa_pkg::DimBits-1:0]     req_pixel_y,
   output logic                             rsp_valid,
   output logic [mbaa_pkg::OutW-1:0]        rsp_iteration_count,
   input  logic                             csr_write_enable,
   input  logic [mbaa_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [mbaa_pkg::RegW-1:0]        csr_write_data
);

   localparam int QW     = mbaa_pkg::DimBits + 4;
   localparam int StepW  = 4;
   localparam int RegW   = mbaa_pkg::RegW;
   localparam int MulW   = mbaa_pkg::MulW;
   localparam int AccW   = mbaa_pkg::AccW;
   localparam int SizeW  = mbaa_pkg::DimBits + 1;
   localparam int CountW = mbaa_pkg::CountW;
   localparam int SumW   = mbaa_pkg::SumW;
   localparam int Frac   = mbaa_pkg::FracBits;

   localparam logic [RegW-2:0]   StepReset   = 63'd28147497671065;
   localparam logic [SizeW-1:0]  WidthReset  = SizeW'(640);
   localparam logic [SizeW-1:0]  HeightReset = SizeW'(480);
   localparam logic [RegW-1:0]   SatMin      = {1'b1, {(RegW-1){1'b0}}};
   localparam logic [RegW-1:0]   SatMax      = {1'b0, {(RegW-1){1'b1}}};
   localparam logic [RegW-1:0]   EscHi       = RegW'(1000) << 40;

   // Mapping sequence, one pass per coordinate
   localparam logic [StepW-1:0] MapQ      = 4'd0;
   localparam logic [StepW-1:0] MapLo     = 4'd1;
   localparam logic [StepW-1:0] MapHi     = 4'd2;
   localparam logic [StepW-1:0] MapDrain  = 4'd3;
   localparam logic [StepW-1:0] MapSat    = 4'd4;
   localparam logic [StepW-1:0] MapCentre = 4'd5;

   // Iteration sequence, one pass per z update
   localparam logic [StepW-1:0] StepPrep   = 4'd0;
   localparam logic [StepW-1:0] IssRr00    = 4'd1;
   localparam logic [StepW-1:0] IssRr01    = 4'd2;
   localparam logic [StepW-1:0] IssRr11    = 4'd3;
   localparam logic [StepW-1:0] IssIi00    = 4'd4;
   localparam logic [StepW-1:0] IssIi01    = 4'd5;
   localparam logic [StepW-1:0] IssIi11    = 4'd6;
   localparam logic [StepW-1:0] IssRi00    = 4'd7;
   localparam logic [StepW-1:0] IssRi01    = 4'd8;
   localparam logic [StepW-1:0] IssRi10    = 4'd9;
   localparam logic [StepW-1:0] IssRi11    = 4'd10;
   localparam logic [StepW-1:0] StepDrain  = 4'd11;
   localparam logic [StepW-1:0] StepCheck  = 4'd12;
   localparam logic [StepW-1:0] StepUpdate = 4'd13;

   localparam logic [1:0] LastIdx = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MAP  = 3'b010,
      ST_ITER = 3'b100
   } state_type;

   function automatic logic [RegW-1:0] sat_add(input logic [RegW-1:0] a,
                                               input logic [RegW-1:0] b);
      logic [RegW-1:0] r;
      r = a + b;
      if (a[RegW-1] == b[RegW-1] && r[RegW-1] != a[RegW-1]) begin
         return a[RegW-1] ? SatMin : SatMax;
      end
      return r;
   endfunction

   function automatic logic [RegW-1:0] sat_sub(input logic [RegW-1:0] a,
                                               input logic [RegW-1:0] b);
      logic [RegW-1:0] r;
      r = a - b;
      if (a[RegW-1] != b[RegW-1] && r[RegW-1] != a[RegW-1]) begin
         return a[RegW-1] ? SatMin : SatMax;
      end
      return r;
   endfunction

   function automatic logic [RegW-1:0] sat_narrow(input logic [AccW-1:0] x);
      if (x[AccW-1:RegW-1] == '0 || x[AccW-1:RegW-1] == '1) begin
         return x[RegW-1:0];
      end
      return x[AccW-1] ? SatMin : SatMax;
   endfunction

   // Control registers
   logic [RegW-1:0]   center_x_ff;
   logic [RegW-1:0]   center_y_ff;
   logic [RegW-2:0]   step_size_ff;
   logic [SizeW-1:0]  image_width_ff;
   logic [SizeW-1:0]  image_height_ff;

   // Sequencer
   state_type          state_ff, state_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [1:0]         coord_ff, coord_in;
   logic [1:0]         sample_ff, sample_in;
   logic [CountW-1:0]  iter_ff, iter_in;
   logic [SumW-1:0]    sum_ff, sum_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Datapath
   logic [mbaa_pkg::DimBits-1:0] px_ff, px_in;
   logic [mbaa_pkg::DimBits-1:0] py_ff, py_in;
   logic               q_neg_ff, q_neg_in;
   logic [QW-2:0]      q_mag_ff, q_mag_in;
   logic [RegW-1:0]    map_ff, map_in;
   logic [RegW-1:0]    cxp_ff, cxp_in;
   logic [RegW-1:0]    cxm_ff, cxm_in;
   logic [RegW-1:0]    cyp_ff, cyp_in;
   logic [RegW-1:0]    cym_ff, cym_in;
   logic [RegW-1:0]    zr_ff, zr_in;
   logic [RegW-1:0]    zi_ff, zi_in;
   logic [RegW-1:0]    mag_r_ff, mag_r_in;
   logic [RegW-1:0]    mag_i_ff, mag_i_in;
   logic               psign_ff, psign_in;
   logic [RegW-1:0]    re_ff, re_in;
   logic [RegW-1:0]    im_ff, im_in;
   logic [mbaa_pkg::OutW-1:0] rsp_count_ff, rsp_count_in;

   // Combinational helpers
   logic [mbaa_pkg::DimBits-1:0] p_sel;
   logic [SizeW-1:0]   size_sel;
   logic [QW-1:0]      q_diff;
   logic [QW-1:0]      q_val;
   logic [AccW-1:0]    map_signed;
   logic [AccW-1:0]    map_shift;
   logic [RegW-1:0]    centre_sel;
   logic [RegW-1:0]    coord_res;
   logic [RegW-1:0]    cr;
   logic [RegW-1:0]    ci;
   logic [AccW-1:0]    n_sum;
   logic [AccW-1:0]    sq_diff;
   logic [AccW-1:0]    p_signed;
   logic               escape;
   logic               finish;
   logic [CountW-1:0]  fin_count;
   logic [SumW-1:0]    sum_total;
   logic [MulW-1:0]    r_lo, r_hi, i_lo, i_hi;

   mbaa_pkg::mac_op_type mac_op;
   logic [AccW-1:0]    acc_a;
   logic [AccW-1:0]    acc_b;
   logic [AccW-1:0]    acc_p;

   mbaa_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc_a (acc_a),
      .acc_b (acc_b),
      .acc_p (acc_p)
   );

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         step_size_ff    <= StepReset;
         image_width_ff  <= WidthReset;
         image_height_ff <= HeightReset;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            mbaa_pkg::CSR_CENTER_X:     center_x_ff     <= csr_write_data;
            mbaa_pkg::CSR_CENTER_Y:     center_y_ff     <= csr_write_data;
            mbaa_pkg::CSR_STEP_SIZE:    step_size_ff    <= csr_write_data[RegW-2:0];
            mbaa_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[SizeW-1:0];
            mbaa_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[SizeW-1:0];
            default: ;
         endcase
      end
   end

   // Sample offset in quarter pixels: 4*(p - size/2) +/- 1
   assign p_sel    = coord_ff[1] ? py_ff : px_ff;
   assign size_sel = coord_ff[1] ? image_height_ff : image_width_ff;
   assign q_diff   = QW'(p_sel) - QW'(size_sel[SizeW-1:1]);
   assign q_val    = {q_diff[QW-3:0], 2'b00} + (coord_ff[0] ? {QW{1'b1}} : QW'(1));

   // Scaled offset, floor-divided by four and clamped to 64 bits
   assign map_signed = q_neg_ff ? (~acc_a + AccW'(1)) : acc_a;
   assign map_shift  = {{2{map_signed[AccW-1]}}, map_signed[AccW-1:2]};
   assign centre_sel = coord_ff[1] ? center_y_ff : center_x_ff;
   assign coord_res  = sat_sub(map_ff, centre_sel);

   // Sample point of the current sample
   assign cr = sample_ff[0] ? cxm_ff : cxp_ff;
   assign ci = sample_ff[1] ? cym_ff : cyp_ff;

   // Escape test and the product terms of the next z
   assign n_sum    = acc_a + acc_b;
   assign escape   = n_sum[AccW-1:RegW] >= EscHi;
   assign sq_diff  = acc_a - acc_b;
   assign p_signed = psign_ff ? (~acc_p + AccW'(1)) : acc_p;

   assign r_lo = mag_r_ff[MulW-1:0];
   assign r_hi = mag_r_ff[RegW-1:MulW];
   assign i_lo = mag_i_ff[MulW-1:0];
   assign i_hi = mag_i_ff[RegW-1:MulW];

   // Issue partial products to the shared multiplier
   always_comb begin
      mac_op = '0;
      if (state_ff == ST_MAP) begin
         case (step_ff)
            MapLo: begin
               mac_op.valid = 1'b1;
               mac_op.clear = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_A;
               mac_op.shift = mbaa_pkg::SH_0;
               mac_op.opa   = MulW'(q_mag_ff);
               mac_op.opb   = step_size_ff[MulW-1:0];
            end
            MapHi: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_A;
               mac_op.shift = mbaa_pkg::SH_32;
               mac_op.opa   = MulW'(q_mag_ff);
               mac_op.opb   = MulW'(step_size_ff[RegW-2:MulW]);
            end
            default: ;
         endcase
      end else if (state_ff == ST_ITER) begin
         case (step_ff)
            IssRr00: begin
               mac_op.valid = 1'b1;
               mac_op.clear = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_A;
               mac_op.shift = mbaa_pkg::SH_0;
               mac_op.opa   = r_lo;
               mac_op.opb   = r_lo;
            end
            IssRr01: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_A;
               mac_op.shift = mbaa_pkg::SH_33;
               mac_op.opa   = r_lo;
               mac_op.opb   = r_hi;
            end
            IssRr11: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_A;
               mac_op.shift = mbaa_pkg::SH_64;
               mac_op.opa   = r_hi;
               mac_op.opb   = r_hi;
            end
            IssIi00: begin
               mac_op.valid = 1'b1;
               mac_op.clear = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_B;
               mac_op.shift = mbaa_pkg::SH_0;
               mac_op.opa   = i_lo;
               mac_op.opb   = i_lo;
            end
            IssIi01: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_B;
               mac_op.shift = mbaa_pkg::SH_33;
               mac_op.opa   = i_lo;
               mac_op.opb   = i_hi;
            end
            IssIi11: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_B;
               mac_op.shift = mbaa_pkg::SH_64;
               mac_op.opa   = i_hi;
               mac_op.opb   = i_hi;
            end
            IssRi00: begin
               mac_op.valid = 1'b1;
               mac_op.clear = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_P;
               mac_op.shift = mbaa_pkg::SH_0;
               mac_op.opa   = r_lo;
               mac_op.opb   = i_lo;
            end
            IssRi01: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_P;
               mac_op.shift = mbaa_pkg::SH_32;
               mac_op.opa   = r_lo;
               mac_op.opb   = i_hi;
            end
            IssRi10: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_P;
               mac_op.shift = mbaa_pkg::SH_32;
               mac_op.opa   = r_hi;
               mac_op.opb   = i_lo;
            end
            IssRi11: begin
               mac_op.valid = 1'b1;
               mac_op.dest  = mbaa_pkg::ACC_P;
               mac_op.shift = mbaa_pkg::SH_64;
               mac_op.opa   = r_hi;
               mac_op.opb   = i_hi;
            end
            default: ;
         endcase
      end
   end

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      coord_in     = coord_ff;
      sample_in    = sample_ff;
      iter_in      = iter_ff;
      sum_in       = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_count_in = rsp_count_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      q_neg_in     = q_neg_ff;
      q_mag_in     = q_mag_ff;
      map_in       = map_ff;
      cxp_in       = cxp_ff;
      cxm_in       = cxm_ff;
      cyp_in       = cyp_ff;
      cym_in       = cym_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      mag_r_in     = mag_r_ff;
      mag_i_in     = mag_i_ff;
      psign_in     = psign_ff;
      re_in        = re_ff;
      im_in        = im_ff;
      finish       = 1'b0;
      fin_count    = iter_ff;
      sum_total    = sum_ff + SumW'(fin_count);

      unique case (state_ff)
         ST_IDLE: begin
            // Take a new pixel and clear the per-pixel state
            if (start) begin
               px_in     = req_pixel_x;
               py_in     = req_pixel_y;
               state_in  = ST_MAP;
               step_in   = MapQ;
               coord_in  = '0;
               sample_in = '0;
               iter_in   = '0;
               sum_in    = '0;
               zr_in     = '0;
               zi_in     = '0;
            end
         end

         ST_MAP: begin
            // Map one coordinate per pass: offset, scale, clamp, subtract centre
            step_in = step_ff + StepW'(1);
            case (step_ff)
               MapQ: begin
                  q_neg_in = q_val[QW-1];
                  q_mag_in = q_val[QW-1] ? (~q_val[QW-2:0] + (QW-1)'(1)) : q_val[QW-2:0];
               end
               MapSat: begin
                  map_in = sat_narrow(map_shift);
               end
               MapCentre: begin
                  case (coord_ff)
                     2'd0:    cxp_in = coord_res;
                     2'd1:    cxm_in = coord_res;
                     2'd2:    cyp_in = coord_res;
                     default: cym_in = coord_res;
                  endcase
                  step_in  = MapQ;
                  coord_in = coord_ff + 2'd1;
                  if (coord_ff == LastIdx) begin
                     state_in = ST_ITER;
                     step_in  = StepPrep;
                  end
               end
               default: ;
            endcase
         end

         ST_ITER: begin
            // One z update per pass through the steps
            step_in = step_ff + StepW'(1);
            case (step_ff)
               StepPrep: begin
                  mag_r_in = zr_ff[RegW-1] ? (~zr_ff + RegW'(1)) : zr_ff;
                  mag_i_in = zi_ff[RegW-1] ? (~zi_ff + RegW'(1)) : zi_ff;
                  psign_in = zr_ff[RegW-1] ^ zi_ff[RegW-1];
               end
               StepCheck: begin
                  re_in = sq_diff[Frac+RegW-1:Frac];
                  im_in = p_signed[Frac+RegW-2:Frac-1];
                  if (escape) begin
                     finish    = 1'b1;
                     fin_count = iter_ff;
                  end
               end
               StepUpdate: begin
                  zr_in   = sat_add(re_ff, cr);
                  zi_in   = sat_add(im_ff, ci);
                  iter_in = iter_ff + CountW'(1);
                  step_in = StepPrep;
                  if (iter_ff == CountW'(mbaa_pkg::MaxIter - 1)) begin
                     finish    = 1'b1;
                     fin_count = CountW'(mbaa_pkg::MaxIter);
                  end
               end
               default: ;
            endcase

            // Close a sample: add its count, then move on or deliver the mean
            sum_total = sum_ff + SumW'(fin_count);
            if (finish) begin
               sum_in    = sum_total;
               zr_in     = '0;
               zi_in     = '0;
               iter_in   = '0;
               step_in   = StepPrep;
               sample_in = sample_ff + 2'd1;
               if (sample_ff == LastIdx) begin
                  rsp_valid_in = 1'b1;
                  rsp_count_in = mbaa_pkg::OutW'(sum_total >> 2);
                  state_in     = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         coord_ff     <= '0;
         sample_ff    <= '0;
         iter_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         coord_ff     <= coord_in;
         sample_ff    <= sample_in;
         iter_ff      <= iter_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      px_ff        <= px_in;
      py_ff        <= py_in;
      q_neg_ff     <= q_neg_in;
      q_mag_ff     <= q_mag_in;
      map_ff       <= map_in;
      cxp_ff       <= cxp_in;
      cxm_ff       <= cxm_in;
      cyp_ff       <= cyp_in;
      cym_ff       <= cym_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      mag_r_ff     <= mag_r_in;
      mag_i_ff     <= mag_i_in;
      psign_ff     <= psign_in;
      re_ff        <= re_in;
      im_ff        <= im_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;

   // A result only follows a busy cycle
   a_rsp_after_busy : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a pixel in flight");

   // An accepted start always makes the block busy
   a_start_busy : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("start transfer not taken");

   // The mean never exceeds the iteration limit
   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_iteration_count <= mbaa_pkg::OutW'(mbaa_pkg::MaxIter)))
      else $error("iteration count beyond limit");

   // The iteration counter wraps to zero before it reaches the limit
   a_iter_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (iter_ff < CountW'(mbaa_pkg::MaxIter)))
      else $error("iteration counter overrun");

   // The step counter stays within one pass
   a_step_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ITER) |-> (step_ff <= StepUpdate))
      else $error("iteration step overrun");

endmodule
